// ===== sv/utf8tg_pkg.sv =====
// Shared types, byte codes and the 5x7 font ROM of the UTF-8 text glyph generator.
// Used by utf8tg_glyph_dec, utf8tg_cursor and utf8_text_glyph_generator.
// No dependencies.
package utf8tg_pkg;

   localparam int COORD_BITS  = 16;
   localparam int CSR_BITS    = 16;
   localparam int SCALE_BITS  = 4;
   localparam int COL_BITS    = 7;
   localparam int GLYPH_COLS  = 5;
   localparam int GIDX_BITS   = 7;
   localparam int STEP_BITS   = 7;

   // configuration register indexes
   localparam logic [1:0] CSR_ORIGIN_X = 2'd0;
   localparam logic [1:0] CSR_ORIGIN_Y = 2'd1;
   localparam logic [1:0] CSR_SCALE    = 2'd2;

   // text byte codes
   localparam logic [7:0] BYTE_NUL      = 8'h00;
   localparam logic [7:0] BYTE_LF       = 8'h0A;
   localparam logic [7:0] BYTE_FIRST_PR = 8'h20;
   localparam logic [7:0] BYTE_LAST_PR  = 8'h7E;
   localparam logic [7:0] BYTE_LEAD_C3  = 8'hC3;
   localparam logic [7:0] BYTE_LEAD_C2  = 8'hC2;
   localparam logic [7:0] TRAIL_A_ACU   = 8'hA1;
   localparam logic [7:0] TRAIL_E_ACU   = 8'hA9;
   localparam logic [7:0] TRAIL_I_ACU   = 8'hAD;
   localparam logic [7:0] TRAIL_O_ACU   = 8'hB3;
   localparam logic [7:0] TRAIL_U_ACU   = 8'hBA;
   localparam logic [7:0] TRAIL_N_TIL   = 8'hB1;
   localparam logic [7:0] TRAIL_CA_ACU  = 8'h81;
   localparam logic [7:0] TRAIL_CE_ACU  = 8'h89;
   localparam logic [7:0] TRAIL_CI_ACU  = 8'h8D;
   localparam logic [7:0] TRAIL_CO_ACU  = 8'h93;
   localparam logic [7:0] TRAIL_CU_ACU  = 8'h9A;
   localparam logic [7:0] TRAIL_CN_TIL  = 8'h91;
   localparam logic [7:0] TRAIL_INV_EXC = 8'hA1;
   localparam logic [7:0] TRAIL_INV_QM  = 8'hBF;
   localparam logic [7:0] TRAIL_DEGREE  = 8'hB0;

   // font ROM indexes
   localparam logic [GIDX_BITS-1:0] GLYPH_BLANK   = 7'd0;
   localparam logic [GIDX_BITS-1:0] GLYPH_QM      = 7'd31;
   localparam logic [GIDX_BITS-1:0] GLYPH_CAP_A   = 7'd33;
   localparam logic [GIDX_BITS-1:0] GLYPH_CAP_E   = 7'd37;
   localparam logic [GIDX_BITS-1:0] GLYPH_CAP_I   = 7'd41;
   localparam logic [GIDX_BITS-1:0] GLYPH_CAP_N   = 7'd46;
   localparam logic [GIDX_BITS-1:0] GLYPH_CAP_O   = 7'd47;
   localparam logic [GIDX_BITS-1:0] GLYPH_CAP_U   = 7'd53;
   localparam logic [GIDX_BITS-1:0] GLYPH_A_ACU   = 7'd95;
   localparam logic [GIDX_BITS-1:0] GLYPH_E_ACU   = 7'd96;
   localparam logic [GIDX_BITS-1:0] GLYPH_I_ACU   = 7'd97;
   localparam logic [GIDX_BITS-1:0] GLYPH_O_ACU   = 7'd98;
   localparam logic [GIDX_BITS-1:0] GLYPH_U_ACU   = 7'd99;
   localparam logic [GIDX_BITS-1:0] GLYPH_N_TIL   = 7'd100;
   localparam logic [GIDX_BITS-1:0] GLYPH_INV_EXC = 7'd101;
   localparam logic [GIDX_BITS-1:0] GLYPH_INV_QM  = 7'd102;
   localparam logic [GIDX_BITS-1:0] GLYPH_DEGREE  = 7'd103;

   typedef enum logic [1:0] {
      LEAD_NONE  = 2'd0,
      LEAD_C3    = 2'd1,
      LEAD_C2    = 2'd2,
      LEAD_OTHER = 2'd3
   } lead_type;

   typedef logic [0:GLYPH_COLS-1][COL_BITS-1:0] glyph_type;

   typedef struct packed {
      logic     emit;
      logic     newline;
      lead_type next_lead;
   } action_type;

   function automatic glyph_type font_glyph(input logic [GIDX_BITS-1:0] idx);
      glyph_type g;
      case (idx)
         7'd0:   g = {7'h00, 7'h00, 7'h00, 7'h00, 7'h00};
         7'd1:   g = {7'h00, 7'h00, 7'h5F, 7'h00, 7'h00};
         7'd2:   g = {7'h00, 7'h07, 7'h00, 7'h07, 7'h00};
         7'd3:   g = {7'h14, 7'h7F, 7'h14, 7'h7F, 7'h14};
         7'd4:   g = {7'h24, 7'h2A, 7'h7F, 7'h2A, 7'h12};
         7'd5:   g = {7'h23, 7'h13, 7'h08, 7'h64, 7'h62};
         7'd6:   g = {7'h36, 7'h49, 7'h55, 7'h22, 7'h50};
         7'd7:   g = {7'h00, 7'h05, 7'h03, 7'h00, 7'h00};
         7'd8:   g = {7'h00, 7'h1C, 7'h22, 7'h41, 7'h00};
         7'd9:   g = {7'h00, 7'h41, 7'h22, 7'h1C, 7'h00};
         7'd10:  g = {7'h14, 7'h08, 7'h3E, 7'h08, 7'h14};
         7'd11:  g = {7'h08, 7'h08, 7'h3E, 7'h08, 7'h08};
         7'd12:  g = {7'h00, 7'h50, 7'h30, 7'h00, 7'h00};
         7'd13:  g = {7'h08, 7'h08, 7'h08, 7'h08, 7'h08};
         7'd14:  g = {7'h00, 7'h60, 7'h60, 7'h00, 7'h00};
         7'd15:  g = {7'h20, 7'h10, 7'h08, 7'h04, 7'h02};
         7'd16:  g = {7'h3E, 7'h51, 7'h49, 7'h45, 7'h3E};
         7'd17:  g = {7'h00, 7'h42, 7'h7F, 7'h40, 7'h00};
         7'd18:  g = {7'h42, 7'h61, 7'h51, 7'h49, 7'h46};
         7'd19:  g = {7'h21, 7'h41, 7'h45, 7'h4B, 7'h31};
         7'd20:  g = {7'h18, 7'h14, 7'h12, 7'h7F, 7'h10};
         7'd21:  g = {7'h27, 7'h45, 7'h45, 7'h45, 7'h39};
         7'd22:  g = {7'h3C, 7'h4A, 7'h49, 7'h49, 7'h30};
         7'd23:  g = {7'h01, 7'h71, 7'h09, 7'h05, 7'h03};
         7'd24:  g = {7'h36, 7'h49, 7'h49, 7'h49, 7'h36};
         7'd25:  g = {7'h06, 7'h49, 7'h49, 7'h29, 7'h1E};
         7'd26:  g = {7'h00, 7'h36, 7'h36, 7'h00, 7'h00};
         7'd27:  g = {7'h00, 7'h56, 7'h36, 7'h00, 7'h00};
         7'd28:  g = {7'h08, 7'h14, 7'h22, 7'h41, 7'h00};
         7'd29:  g = {7'h14, 7'h14, 7'h14, 7'h14, 7'h14};
         7'd30:  g = {7'h00, 7'h41, 7'h22, 7'h14, 7'h08};
         7'd31:  g = {7'h02, 7'h01, 7'h51, 7'h09, 7'h06};
         7'd32:  g = {7'h32, 7'h49, 7'h79, 7'h41, 7'h3E};
         7'd33:  g = {7'h7E, 7'h11, 7'h11, 7'h11, 7'h7E};
         7'd34:  g = {7'h7F, 7'h49, 7'h49, 7'h49, 7'h36};
         7'd35:  g = {7'h3E, 7'h41, 7'h41, 7'h41, 7'h22};
         7'd36:  g = {7'h7F, 7'h41, 7'h41, 7'h22, 7'h1C};
         7'd37:  g = {7'h7F, 7'h49, 7'h49, 7'h49, 7'h41};
         7'd38:  g = {7'h7F, 7'h09, 7'h09, 7'h09, 7'h01};
         7'd39:  g = {7'h3E, 7'h41, 7'h49, 7'h49, 7'h7A};
         7'd40:  g = {7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F};
         7'd41:  g = {7'h00, 7'h41, 7'h7F, 7'h41, 7'h00};
         7'd42:  g = {7'h20, 7'h40, 7'h41, 7'h3F, 7'h01};
         7'd43:  g = {7'h7F, 7'h08, 7'h14, 7'h22, 7'h41};
         7'd44:  g = {7'h7F, 7'h40, 7'h40, 7'h40, 7'h40};
         7'd45:  g = {7'h7F, 7'h02, 7'h0C, 7'h02, 7'h7F};
         7'd46:  g = {7'h7F, 7'h04, 7'h08, 7'h10, 7'h7F};
         7'd47:  g = {7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E};
         7'd48:  g = {7'h7F, 7'h09, 7'h09, 7'h09, 7'h06};
         7'd49:  g = {7'h3E, 7'h41, 7'h51, 7'h21, 7'h5E};
         7'd50:  g = {7'h7F, 7'h09, 7'h19, 7'h29, 7'h46};
         7'd51:  g = {7'h46, 7'h49, 7'h49, 7'h49, 7'h31};
         7'd52:  g = {7'h01, 7'h01, 7'h7F, 7'h01, 7'h01};
         7'd53:  g = {7'h3F, 7'h40, 7'h40, 7'h40, 7'h3F};
         7'd54:  g = {7'h1F, 7'h20, 7'h40, 7'h20, 7'h1F};
         7'd55:  g = {7'h3F, 7'h40, 7'h38, 7'h40, 7'h3F};
         7'd56:  g = {7'h63, 7'h14, 7'h08, 7'h14, 7'h63};
         7'd57:  g = {7'h07, 7'h08, 7'h70, 7'h08, 7'h07};
         7'd58:  g = {7'h61, 7'h51, 7'h49, 7'h45, 7'h43};
         7'd59:  g = {7'h00, 7'h7F, 7'h41, 7'h41, 7'h00};
         7'd60:  g = {7'h02, 7'h04, 7'h08, 7'h10, 7'h20};
         7'd61:  g = {7'h00, 7'h41, 7'h41, 7'h7F, 7'h00};
         7'd62:  g = {7'h04, 7'h02, 7'h01, 7'h02, 7'h04};
         7'd63:  g = {7'h40, 7'h40, 7'h40, 7'h40, 7'h40};
         7'd64:  g = {7'h00, 7'h01, 7'h02, 7'h04, 7'h00};
         7'd65:  g = {7'h20, 7'h54, 7'h54, 7'h54, 7'h78};
         7'd66:  g = {7'h7F, 7'h48, 7'h44, 7'h44, 7'h38};
         7'd67:  g = {7'h38, 7'h44, 7'h44, 7'h44, 7'h20};
         7'd68:  g = {7'h38, 7'h44, 7'h44, 7'h48, 7'h7F};
         7'd69:  g = {7'h38, 7'h54, 7'h54, 7'h54, 7'h18};
         7'd70:  g = {7'h08, 7'h7E, 7'h09, 7'h01, 7'h02};
         7'd71:  g = {7'h58, 7'h64, 7'h64, 7'h64, 7'h3C};
         7'd72:  g = {7'h7F, 7'h08, 7'h04, 7'h04, 7'h78};
         7'd73:  g = {7'h00, 7'h44, 7'h7D, 7'h40, 7'h00};
         7'd74:  g = {7'h20, 7'h40, 7'h44, 7'h3D, 7'h00};
         7'd75:  g = {7'h7F, 7'h10, 7'h28, 7'h44, 7'h00};
         7'd76:  g = {7'h00, 7'h41, 7'h7F, 7'h40, 7'h00};
         7'd77:  g = {7'h7C, 7'h04, 7'h18, 7'h04, 7'h78};
         7'd78:  g = {7'h7C, 7'h08, 7'h04, 7'h04, 7'h78};
         7'd79:  g = {7'h38, 7'h44, 7'h44, 7'h44, 7'h38};
         7'd80:  g = {7'h7C, 7'h14, 7'h14, 7'h14, 7'h08};
         7'd81:  g = {7'h08, 7'h14, 7'h14, 7'h18, 7'h7C};
         7'd82:  g = {7'h7C, 7'h08, 7'h04, 7'h04, 7'h08};
         7'd83:  g = {7'h48, 7'h54, 7'h54, 7'h54, 7'h20};
         7'd84:  g = {7'h04, 7'h3F, 7'h44, 7'h40, 7'h20};
         7'd85:  g = {7'h3C, 7'h40, 7'h40, 7'h20, 7'h7C};
         7'd86:  g = {7'h1C, 7'h20, 7'h40, 7'h20, 7'h1C};
         7'd87:  g = {7'h3C, 7'h40, 7'h30, 7'h40, 7'h3C};
         7'd88:  g = {7'h44, 7'h28, 7'h10, 7'h28, 7'h44};
         7'd89:  g = {7'h0C, 7'h50, 7'h50, 7'h50, 7'h3C};
         7'd90:  g = {7'h44, 7'h64, 7'h54, 7'h4C, 7'h44};
         7'd91:  g = {7'h00, 7'h08, 7'h36, 7'h41, 7'h00};
         7'd92:  g = {7'h00, 7'h00, 7'h7F, 7'h00, 7'h00};
         7'd93:  g = {7'h00, 7'h41, 7'h36, 7'h08, 7'h00};
         7'd94:  g = {7'h08, 7'h08, 7'h2A, 7'h1C, 7'h08};
         // accented vowels, enie, inverted marks, degree
         7'd95:  g = {7'h20, 7'h56, 7'h55, 7'h54, 7'h78};
         7'd96:  g = {7'h38, 7'h56, 7'h55, 7'h54, 7'h18};
         7'd97:  g = {7'h00, 7'h46, 7'h7D, 7'h40, 7'h00};
         7'd98:  g = {7'h38, 7'h46, 7'h45, 7'h44, 7'h38};
         7'd99:  g = {7'h3C, 7'h42, 7'h41, 7'h20, 7'h7C};
         7'd100: g = {7'h7E, 7'h09, 7'h05, 7'h06, 7'h7A};
         7'd101: g = {7'h00, 7'h00, 7'h7D, 7'h00, 7'h00};
         7'd102: g = {7'h30, 7'h48, 7'h45, 7'h40, 7'h20};
         7'd103: g = {7'h00, 7'h07, 7'h05, 7'h07, 7'h00};
         default: g = {7'h00, 7'h00, 7'h00, 7'h00, 7'h00};
      endcase
      return g;
   endfunction

endpackage

// ===== sv/utf8tg_glyph_dec.sv =====
// Byte decoder: UTF-8 lead/trail handling, font index selection and ROM lookup.
// Depends on utf8tg_pkg.
module utf8tg_glyph_dec (
   input  logic [7:0]            text_byte,
   input  logic                  string_end,
   input  utf8tg_pkg::lead_type  lead_kind,
   output utf8tg_pkg::action_type action,
   output utf8tg_pkg::glyph_type  glyph
);
   import utf8tg_pkg::*;

   logic [GIDX_BITS-1:0] ascii_idx;
   logic [GIDX_BITS-1:0] pair_idx;
   logic [GIDX_BITS-1:0] glyph_idx;

   // control bytes and DEL map to the blank cell
   always_comb begin
      if (text_byte < BYTE_FIRST_PR || text_byte > BYTE_LAST_PR) begin
         ascii_idx = GLYPH_BLANK;
      end else begin
         ascii_idx = GIDX_BITS'(text_byte - BYTE_FIRST_PR);
      end
   end

   always_comb begin
      pair_idx = GLYPH_QM;
      case (lead_kind)
         LEAD_C3: begin
            case (text_byte)
               TRAIL_A_ACU:  pair_idx = GLYPH_A_ACU;
               TRAIL_E_ACU:  pair_idx = GLYPH_E_ACU;
               TRAIL_I_ACU:  pair_idx = GLYPH_I_ACU;
               TRAIL_O_ACU:  pair_idx = GLYPH_O_ACU;
               TRAIL_U_ACU:  pair_idx = GLYPH_U_ACU;
               TRAIL_N_TIL:  pair_idx = GLYPH_N_TIL;
               TRAIL_CA_ACU: pair_idx = GLYPH_CAP_A;
               TRAIL_CE_ACU: pair_idx = GLYPH_CAP_E;
               TRAIL_CI_ACU: pair_idx = GLYPH_CAP_I;
               TRAIL_CO_ACU: pair_idx = GLYPH_CAP_O;
               TRAIL_CU_ACU: pair_idx = GLYPH_CAP_U;
               TRAIL_CN_TIL: pair_idx = GLYPH_CAP_N;
               default:      pair_idx = GLYPH_QM;
            endcase
         end
         LEAD_C2: begin
            case (text_byte)
               TRAIL_INV_EXC: pair_idx = GLYPH_INV_EXC;
               TRAIL_INV_QM:  pair_idx = GLYPH_INV_QM;
               TRAIL_DEGREE:  pair_idx = GLYPH_DEGREE;
               default:       pair_idx = GLYPH_QM;
            endcase
         end
         default: pair_idx = GLYPH_QM;
      endcase
   end

   always_comb begin
      action.emit      = 1'b0;
      action.newline   = 1'b0;
      action.next_lead = LEAD_NONE;
      glyph_idx        = ascii_idx;
      if (lead_kind != LEAD_NONE) begin
         // any byte after a lead closes the pair
         action.emit = 1'b1;
         glyph_idx   = pair_idx;
      end else if (text_byte == BYTE_NUL) begin
         action.emit = 1'b0;
      end else if (text_byte == BYTE_LF) begin
         action.newline = 1'b1;
      end else if (!text_byte[7]) begin
         action.emit = 1'b1;
      end else if (string_end) begin
         // lead with nothing to follow
         action.emit = 1'b1;
         glyph_idx   = GLYPH_QM;
      end else if (text_byte == BYTE_LEAD_C3) begin
         action.next_lead = LEAD_C3;
      end else if (text_byte == BYTE_LEAD_C2) begin
         action.next_lead = LEAD_C2;
      end else begin
         action.next_lead = LEAD_OTHER;
      end
   end

   assign glyph = font_glyph(glyph_idx);

endmodule

// ===== sv/utf8tg_cursor.sv =====
// Cursor and pending-lead state with saturating advance and newline.
// Depends on utf8tg_pkg.
module utf8tg_cursor (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  step,
   input  logic                                  string_start,
   input  utf8tg_pkg::action_type                action,
   input  logic signed [utf8tg_pkg::COORD_BITS-1:0] origin_x,
   input  logic signed [utf8tg_pkg::COORD_BITS-1:0] origin_y,
   input  logic [utf8tg_pkg::SCALE_BITS-1:0]     scale,
   output logic signed [utf8tg_pkg::COORD_BITS-1:0] pos_x,
   output logic signed [utf8tg_pkg::COORD_BITS-1:0] pos_y,
   output utf8tg_pkg::lead_type                  lead_kind
);
   import utf8tg_pkg::*;

   logic signed [COORD_BITS-1:0] cursor_x_ff, cursor_x_in;
   logic signed [COORD_BITS-1:0] cursor_y_ff, cursor_y_in;
   lead_type                     lead_ff, lead_in;
   logic [SCALE_BITS-1:0]        eff_scale;
   logic [STEP_BITS-1:0]         adv_x;
   logic [STEP_BITS-1:0]         adv_y;

   // add a positive step, clamp at the signed maximum
   function automatic logic signed [COORD_BITS-1:0] sat_add(
      input logic signed [COORD_BITS-1:0] v,
      input logic [STEP_BITS-1:0]         inc
   );
      logic signed [COORD_BITS:0] sum;
      sum = {v[COORD_BITS-1], v} + (COORD_BITS+1)'(inc);
      if (!sum[COORD_BITS] && sum[COORD_BITS-1]) begin
         return {1'b0, {(COORD_BITS-1){1'b1}}};
      end
      return sum[COORD_BITS-1:0];
   endfunction

   assign eff_scale = (scale == '0) ? SCALE_BITS'(1) : scale;
   assign adv_x     = STEP_BITS'({eff_scale, 2'b00}) + STEP_BITS'({eff_scale, 1'b0});
   assign adv_y     = STEP_BITS'({eff_scale, 3'b000});

   // string start takes effect before the byte is handled
   assign pos_x     = string_start ? origin_x : cursor_x_ff;
   assign pos_y     = string_start ? origin_y : cursor_y_ff;
   assign lead_kind = string_start ? LEAD_NONE : lead_ff;

   always_comb begin
      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      lead_in     = lead_ff;
      if (step) begin
         cursor_x_in = pos_x;
         cursor_y_in = pos_y;
         lead_in     = action.next_lead;
         if (action.emit) begin
            cursor_x_in = sat_add(pos_x, adv_x);
         end else if (action.newline) begin
            cursor_x_in = origin_x;
            cursor_y_in = sat_add(pos_y, adv_y);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff <= '0;
         cursor_y_ff <= '0;
         lead_ff     <= LEAD_NONE;
      end else begin
         cursor_x_ff <= cursor_x_in;
         cursor_y_ff <= cursor_y_in;
         lead_ff     <= lead_in;
      end
   end

endmodule

// ===== sv/utf8_text_glyph_generator.sv =====
// Top level of the UTF-8 text glyph generator: input register, config registers,
// result register. Depends on utf8tg_pkg, utf8tg_glyph_dec and utf8tg_cursor.
//
//   channel  | ports                 | beat
//   ---------+-----------------------+------------------------------------------
//   req      | req_valid / req_stall | one text byte with start/end flags
//   rsp      | rsp_valid / rsp_stall | one glyph: position and five columns
//   csr      | csr_write_en          | one register write, no wait
//
// One byte per cycle sustained while rsp_stall is low. A byte waits in the input
// register, where the decoder, font ROM and cursor adder act on it, and its glyph
// lands in the result register. Newline and zero bytes give no beat.
// Synchronous reset clears valids, cursor and pending lead; registers take
// origin 0,0 and scale 1. A stalled result holds; the input register still
// takes one more byte, and req_stall rises only when both registers are full.
module utf8_text_glyph_generator (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [7:0]                            req_text_byte,
   input  logic                                  req_string_start,
   input  logic                                  req_string_end,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [utf8tg_pkg::COORD_BITS-1:0] rsp_glyph_x,
   output logic signed [utf8tg_pkg::COORD_BITS-1:0] rsp_glyph_y,
   output logic [utf8tg_pkg::COL_BITS-1:0]       rsp_column_0,
   output logic [utf8tg_pkg::COL_BITS-1:0]       rsp_column_1,
   output logic [utf8tg_pkg::COL_BITS-1:0]       rsp_column_2,
   output logic [utf8tg_pkg::COL_BITS-1:0]       rsp_column_3,
   output logic [utf8tg_pkg::COL_BITS-1:0]       rsp_column_4,
   output logic                                  rsp_end_of_text,
   input  logic                                  csr_write_en,
   input  logic [1:0]                            csr_index,
   input  logic [utf8tg_pkg::CSR_BITS-1:0]       csr_wdata
);
   import utf8tg_pkg::*;

   // configuration
   logic signed [COORD_BITS-1:0] origin_x_ff;
   logic signed [COORD_BITS-1:0] origin_y_ff;
   logic [SCALE_BITS-1:0]        scale_ff;

   // input register
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       s1_start_ff;
   logic       s1_end_ff;

   // result register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_BITS-1:0] rsp_x_ff;
   logic signed [COORD_BITS-1:0] rsp_y_ff;
   glyph_type                    rsp_glyph_ff;
   logic                         rsp_end_ff;

   logic                         req_accept;
   logic                         out_free;
   logic                         advance;
   action_type                   action;
   glyph_type                    glyph;
   lead_type                     lead_kind;
   logic signed [COORD_BITS-1:0] pos_x;
   logic signed [COORD_BITS-1:0] pos_y;

   utf8tg_glyph_dec u_dec (
      .text_byte  (s1_byte_ff),
      .string_end (s1_end_ff),
      .lead_kind  (lead_kind),
      .action     (action),
      .glyph      (glyph)
   );

   utf8tg_cursor u_cursor (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .string_start (s1_start_ff),
      .action       (action),
      .origin_x     (origin_x_ff),
      .origin_y     (origin_y_ff),
      .scale        (scale_ff),
      .pos_x        (pos_x),
      .pos_y        (pos_y),
      .lead_kind    (lead_kind)
   );

   // a byte with no glyph leaves without waiting for the result register
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign advance    = s1_valid_ff && (!action.emit || out_free);
   assign req_stall  = s1_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && action.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         scale_ff    <= SCALE_BITS'(1);
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_ORIGIN_X: origin_x_ff <= csr_wdata[COORD_BITS-1:0];
            CSR_ORIGIN_Y: origin_y_ff <= csr_wdata[COORD_BITS-1:0];
            CSR_SCALE:    scale_ff    <= csr_wdata[SCALE_BITS-1:0];
            default:      scale_ff    <= scale_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_byte_ff  <= req_text_byte;
         s1_start_ff <= req_string_start;
         s1_end_ff   <= req_string_end;
      end
      if (advance && action.emit) begin
         rsp_x_ff     <= pos_x;
         rsp_y_ff     <= pos_y;
         rsp_glyph_ff <= glyph;
         rsp_end_ff   <= s1_end_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_glyph_x     = rsp_x_ff;
   assign rsp_glyph_y     = rsp_y_ff;
   assign rsp_column_0    = rsp_glyph_ff[0];
   assign rsp_column_1    = rsp_glyph_ff[1];
   assign rsp_column_2    = rsp_glyph_ff[2];
   assign rsp_column_3    = rsp_glyph_ff[3];
   assign rsp_column_4    = rsp_glyph_ff[4];
   assign rsp_end_of_text = rsp_end_ff;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled while a register has room");

   a_emit_fills_result: assert property (@(posedge clock) disable iff (reset)
      (advance && action.emit) |=> rsp_valid_ff)
      else $error("emitted glyph did not reach the result register");

   a_end_drops_lead: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_end_ff) |-> (action.next_lead == LEAD_NONE))
      else $error("lead byte left pending past string end");

   a_lead_no_glyph: assert property (@(posedge clock) disable iff (reset)
      (advance && action.next_lead != LEAD_NONE) |-> (!action.emit && !action.newline))
      else $error("lead byte produced a glyph or a line break");

endmodule

// ===== verif/tb_utf8_text_glyph_generator.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for utf8_text_glyph_generator: directed text rows, then random
// UTF-8 streams under several origin/scale settings, checked beat by beat against a local
// glyph and cursor predictor. Depends on utf8tg_pkg and the RTL top level only.
module tb_utf8_text_glyph_generator;
   import utf8tg_pkg::*;

   localparam int COORD_MAX    = (1 << (COORD_BITS - 1)) - 1;
   localparam int COORD_MIN    = -COORD_MAX - 1;
   localparam int PIPE_SETTLE  = 4;
   localparam int PHASE_BYTES  = 68;
   localparam int NUM_PHASES   = 7;

   // text byte codes
   localparam logic [7:0] CH_NUL       = 8'h00;
   localparam logic [7:0] CH_LF        = 8'h0A;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_TILDE     = 8'h7E;
   localparam logic [7:0] CH_DEL       = 8'h7F;
   localparam logic [7:0] CH_HIGH      = 8'h80;
   localparam logic [7:0] CH_LEAD_C3   = 8'hC3;
   localparam logic [7:0] CH_LEAD_C2   = 8'hC2;
   localparam logic [7:0] TR_A_ACUTE   = 8'hA1;
   localparam logic [7:0] TR_E_ACUTE   = 8'hA9;
   localparam logic [7:0] TR_I_ACUTE   = 8'hAD;
   localparam logic [7:0] TR_O_ACUTE   = 8'hB3;
   localparam logic [7:0] TR_U_ACUTE   = 8'hBA;
   localparam logic [7:0] TR_N_TILDE   = 8'hB1;
   localparam logic [7:0] TR_CAP_A     = 8'h81;
   localparam logic [7:0] TR_CAP_E     = 8'h89;
   localparam logic [7:0] TR_CAP_I     = 8'h8D;
   localparam logic [7:0] TR_CAP_O     = 8'h93;
   localparam logic [7:0] TR_CAP_U     = 8'h9A;
   localparam logic [7:0] TR_CAP_N     = 8'h91;
   localparam logic [7:0] TR_INV_EXCL  = 8'hA1;
   localparam logic [7:0] TR_INV_QUEST = 8'hBF;
   localparam logic [7:0] TR_DEGREE    = 8'hB0;

   // glyphs outside printable ASCII, five columns packed high to low
   localparam logic [39:0] GL_A_ACUTE   = 40'h2056555478;
   localparam logic [39:0] GL_E_ACUTE   = 40'h3856555418;
   localparam logic [39:0] GL_I_ACUTE   = 40'h00467D4000;
   localparam logic [39:0] GL_O_ACUTE   = 40'h3846454438;
   localparam logic [39:0] GL_U_ACUTE   = 40'h3C4241207C;
   localparam logic [39:0] GL_N_TILDE   = 40'h7E0905067A;
   localparam logic [39:0] GL_INV_EXCL  = 40'h00007D0000;
   localparam logic [39:0] GL_INV_QUEST = 40'h3048454020;
   localparam logic [39:0] GL_DEGREE    = 40'h0007050700;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [39:0]        cols;
      logic               eot;
   } glyph_beat_type;

   typedef struct packed {
      logic [7:0]     b;
      logic           s;
      logic           e;
      logic           typed;
      glyph_beat_type beat;
   } text_row_type;

   logic [39:0] ascii_font [0:94] = '{
      40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
      40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
      40'h14083E0814, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
      40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
      40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
      40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
      40'h0041221408, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F49494936,
      40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
      40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
      40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
      40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
      40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
      40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040, 40'h0001020400,
      40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
      40'h087E090102, 40'h586464643C, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
      40'h7F10284400, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
      40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
      40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
      40'h4464544C44, 40'h0008364100, 40'h00007F0000, 40'h0041360800, 40'h08082A1C08
   };

   logic [7:0] c3_trails [0:11] = '{TR_A_ACUTE, TR_E_ACUTE, TR_I_ACUTE, TR_O_ACUTE,
      TR_U_ACUTE, TR_N_TILDE, TR_CAP_A, TR_CAP_E, TR_CAP_I, TR_CAP_O, TR_CAP_U, TR_CAP_N};
   logic [7:0] c2_trails [0:2] = '{TR_INV_EXCL, TR_INV_QUEST, TR_DEGREE};

   // DUT ports
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [7:0]            req_text_byte = 8'h00;
   logic                  req_string_start = 1'b0;
   logic                  req_string_end = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic signed [COORD_BITS-1:0] rsp_glyph_x;
   logic signed [COORD_BITS-1:0] rsp_glyph_y;
   logic [COL_BITS-1:0]   rsp_column_0;
   logic [COL_BITS-1:0]   rsp_column_1;
   logic [COL_BITS-1:0]   rsp_column_2;
   logic [COL_BITS-1:0]   rsp_column_3;
   logic [COL_BITS-1:0]   rsp_column_4;
   logic                  rsp_end_of_text;
   logic                  csr_write_en = 1'b0;
   logic [1:0]            csr_index = CSR_ORIGIN_X;
   logic [CSR_BITS-1:0]   csr_wdata = '0;

   // predictor state and register shadow
   int          org_x = 0;
   int          org_y = 0;
   logic [3:0]  scale_reg = 4'd1;
   int          cur_x = 0;
   int          cur_y = 0;
   lead_type    pend_lead = LEAD_NONE;

   glyph_beat_type pending_glyphs [$];
   text_row_type   text_rows [$];

   int err_count = 0;
   int byte_count = 0;
   int glyph_count = 0;
   int pair_count = 0;
   int line_count = 0;
   int sat_count = 0;
   int setting_count = 0;
   int burst_left = 0;

   utf8_text_glyph_generator dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_text_byte    (req_text_byte),
      .req_string_start (req_string_start),
      .req_string_end   (req_string_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_glyph_x      (rsp_glyph_x),
      .rsp_glyph_y      (rsp_glyph_y),
      .rsp_column_0     (rsp_column_0),
      .rsp_column_1     (rsp_column_1),
      .rsp_column_2     (rsp_column_2),
      .rsp_column_3     (rsp_column_3),
      .rsp_column_4     (rsp_column_4),
      .rsp_end_of_text  (rsp_end_of_text),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tb_utf8_text_glyph_generator: done, errors");
      $finish;
   end

   function automatic int clamp_coord(input int v);
      if (v > COORD_MAX) begin
         sat_count++;
         return COORD_MAX;
      end
      if (v < COORD_MIN) begin
         sat_count++;
         return COORD_MIN;
      end
      return v;
   endfunction

   function automatic logic [39:0] ascii_glyph(input logic [7:0] b);
      if (b < CH_SPACE || b > CH_TILDE) return ascii_font[0];
      return ascii_font[b - CH_SPACE];
   endfunction

   function automatic logic [39:0] pair_glyph(input lead_type k, input logic [7:0] b);
      if (k == LEAD_C3) begin
         case (b)
            TR_A_ACUTE: return GL_A_ACUTE;
            TR_E_ACUTE: return GL_E_ACUTE;
            TR_I_ACUTE: return GL_I_ACUTE;
            TR_O_ACUTE: return GL_O_ACUTE;
            TR_U_ACUTE: return GL_U_ACUTE;
            TR_N_TILDE: return GL_N_TILDE;
            TR_CAP_A:   return ascii_glyph("A");
            TR_CAP_E:   return ascii_glyph("E");
            TR_CAP_I:   return ascii_glyph("I");
            TR_CAP_O:   return ascii_glyph("O");
            TR_CAP_U:   return ascii_glyph("U");
            TR_CAP_N:   return ascii_glyph("N");
            default:    return ascii_glyph("?");
         endcase
      end
      if (k == LEAD_C2) begin
         case (b)
            TR_INV_EXCL:  return GL_INV_EXCL;
            TR_INV_QUEST: return GL_INV_QUEST;
            TR_DEGREE:    return GL_DEGREE;
            default:      return ascii_glyph("?");
         endcase
      end
      return ascii_glyph("?");
   endfunction

   // Advance the cursor/lead state by one text byte; return 1 when a glyph comes out.
   function automatic bit render_byte(input logic [7:0] b, input logic s, input logic e,
                                      output glyph_beat_type g);
      lead_type    k;
      int          step;
      bit          emits;
      logic [39:0] cols;
      step  = (scale_reg == 4'd0) ? 1 : int'(scale_reg);
      emits = 1'b0;
      cols  = '0;
      g     = '0;
      if (s) begin
         cur_x     = clamp_coord(org_x);
         cur_y     = clamp_coord(org_y);
         pend_lead = LEAD_NONE;
      end
      if (pend_lead != LEAD_NONE) begin
         // whatever follows a lead closes the pair, even zero or newline
         k         = pend_lead;
         pend_lead = LEAD_NONE;
         cols      = pair_glyph(k, b);
         emits     = 1'b1;
         pair_count++;
      end else if (b == CH_NUL) begin
         // string terminator: nothing to draw
      end else if (b == CH_LF) begin
         cur_x = clamp_coord(org_x);
         cur_y = clamp_coord(cur_y + 8 * step);
         line_count++;
      end else if (b < CH_HIGH) begin
         cols  = ascii_glyph(b);
         emits = 1'b1;
      end else if (e) begin
         cols  = ascii_glyph("?");
         emits = 1'b1;
      end else if (b == CH_LEAD_C3) begin
         pend_lead = LEAD_C3;
      end else if (b == CH_LEAD_C2) begin
         pend_lead = LEAD_C2;
      end else begin
         pend_lead = LEAD_OTHER;
      end
      if (emits) begin
         g.x    = cur_x[15:0];
         g.y    = cur_y[15:0];
         g.cols = cols;
         g.eot  = e;
         cur_x  = clamp_coord(cur_x + 6 * step);
         glyph_count++;
      end
      if (e) pend_lead = LEAD_NONE;
      return emits;
   endfunction

   function automatic text_row_type text_row(input logic [7:0] b, input logic s,
                                             input logic e, input logic typed,
                                             input int x, input int y,
                                             input logic [39:0] cols, input logic eot);
      text_row_type r;
      r.b         = b;
      r.s         = s;
      r.e         = e;
      r.typed     = typed;
      r.beat.x    = x[15:0];
      r.beat.y    = y[15:0];
      r.beat.cols = cols;
      r.beat.eot  = eot;
      return r;
   endfunction

   // Present one byte, hold it until accepted, then take a burst gap if one is due.
   task automatic send_byte(input logic [7:0] b, input logic s, input logic e,
                            input logic typed, input glyph_beat_type typed_beat);
      glyph_beat_type g;
      bit             emits;
      int             gap;
      req_valid        <= 1'b1;
      req_text_byte    <= b;
      req_string_start <= s;
      req_string_end   <= e;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      emits = render_byte(b, s, e, g);
      if (typed) pending_glyphs.push_back(typed_beat);
      else if (emits) pending_glyphs.push_back(g);
      byte_count++;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   // Hold the sender until every glyph has come back and the pipeline is empty.
   task automatic drain_glyphs();
      req_valid <= 1'b0;
      while (pending_glyphs.size() != 0) @(posedge clock);
      repeat (PIPE_SETTLE) @(posedge clock);
   endtask

   task automatic write_regs(input int ox, input int oy, input logic [3:0] sc);
      logic [11:0] junk;
      junk = 12'($urandom);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_ORIGIN_X;
      csr_wdata    <= ox[15:0];
      @(posedge clock);
      org_x = int'($signed(ox[15:0]));
      csr_index    <= CSR_ORIGIN_Y;
      csr_wdata    <= oy[15:0];
      @(posedge clock);
      org_y = int'($signed(oy[15:0]));
      // upper data bits are don't-care for the scale register
      csr_index    <= CSR_SCALE;
      csr_wdata    <= {junk, sc};
      @(posedge clock);
      scale_reg = sc;
      csr_write_en <= 1'b0;
      setting_count++;
   endtask

   // Mostly well-formed text: ASCII, newlines and valid pairs, with broken pairs and noise.
   task automatic send_random_text(input int n);
      logic [7:0] seq [0:1];
      int         nb;
      int         sent;
      int         kind;
      bit         force_end;
      logic       s;
      logic       e;
      sent = 0;
      while (sent < n) begin
         kind      = $urandom_range(0, 99);
         nb        = 1;
         force_end = 1'b0;
         if (kind < 40) begin
            seq[0] = 8'($urandom_range(CH_SPACE, CH_TILDE));
         end else if (kind < 48) begin
            seq[0] = CH_LF;
         end else if (kind < 68) begin
            nb = 2;
            if ($urandom_range(0, 3) != 0) begin
               seq[0] = CH_LEAD_C3;
               seq[1] = c3_trails[$urandom_range(0, 11)];
            end else begin
               seq[0] = CH_LEAD_C2;
               seq[1] = c2_trails[$urandom_range(0, 2)];
            end
         end else if (kind < 76) begin
            nb = 2;
            case ($urandom_range(0, 2))
               0:       seq[0] = CH_LEAD_C3;
               1:       seq[0] = CH_LEAD_C2;
               default: seq[0] = 8'($urandom_range(CH_HIGH, 8'hFF));
            endcase
            seq[1] = 8'($urandom_range(0, 255));
         end else if (kind < 80) begin
            seq[0]    = 8'($urandom_range(CH_HIGH, 8'hFF));
            force_end = 1'b1;
         end else if (kind < 86) begin
            seq[0] = ($urandom_range(0, 4) == 0) ? CH_DEL : 8'($urandom_range(1, 31));
         end else if (kind < 89) begin
            seq[0] = CH_NUL;
         end else begin
            seq[0] = 8'($urandom_range(0, 255));
         end
         for (int i = 0; i < nb; i++) begin
            s = (i == 0 && $urandom_range(0, 11) == 0) || $urandom_range(0, 39) == 0;
            e = force_end || (i == nb - 1 && $urandom_range(0, 11) == 0) ||
                $urandom_range(0, 39) == 0;
            send_byte(seq[i], s, e, 1'b0, '0);
         end
         sent += nb;
         if ($urandom_range(0, 99) == 0) drain_glyphs();
      end
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         err_count++;
      end
   endtask

   always @(posedge clock) begin : rsp_check
      glyph_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_glyphs.size() == 0) begin
            $error("glyph beat with none expected: x=%0d y=%0d", rsp_glyph_x, rsp_glyph_y);
            err_count++;
         end else begin
            want = pending_glyphs.pop_front();
            check_field("glyph_x", want.x, rsp_glyph_x);
            check_field("glyph_y", want.y, rsp_glyph_y);
            check_field("column_0", want.cols[38 -: 7], rsp_column_0);
            check_field("column_1", want.cols[30 -: 7], rsp_column_1);
            check_field("column_2", want.cols[22 -: 7], rsp_column_2);
            check_field("column_3", want.cols[14 -: 7], rsp_column_3);
            check_field("column_4", want.cols[6 -: 7], rsp_column_4);
            check_field("end_of_text", want.eot, rsp_end_of_text);
         end
      end
   end

   // Receiver back-pressure: runs of free flow, light, heavy and alternating stalls.
   always @(posedge clock) begin : rsp_backpressure
      static int mode = 0;
      static int run  = 0;
      if (run == 0) begin
         mode = $urandom_range(0, 3);
         run  = $urandom_range(16, 96);
      end else begin
         run--;
      end
      case (mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 3) == 0);
         2:       rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= run[0];
      endcase
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // after reset: origin 0,0 and scale 1, so positions step by 6
      text_rows.push_back(text_row(8'h41, 1, 0, 1, 0, 0, 40'h7E1111117E, 0));
      text_rows.push_back(text_row(CH_SPACE, 0, 0, 1, 6, 0, 40'h0000000000, 0));
      text_rows.push_back(text_row(CH_TILDE, 0, 0, 1, 12, 0, 40'h08082A1C08, 0));
      text_rows.push_back(text_row(CH_DEL, 0, 0, 1, 18, 0, 40'h0000000000, 0));
      text_rows.push_back(text_row(8'h01, 0, 0, 1, 24, 0, 40'h0000000000, 0));
      text_rows.push_back(text_row(CH_LF, 0, 0, 0, 0, 0, '0, 0));
      text_rows.push_back(text_row(CH_LEAD_C3, 0, 0, 0, 0, 0, '0, 0));
      text_rows.push_back(text_row(TR_A_ACUTE, 0, 0, 0, 0, 0, '0, 0));
      text_rows.push_back(text_row(CH_LEAD_C3, 0, 0, 0, 0, 0, '0, 0));
      text_rows.push_back(text_row(TR_N_TILDE, 0, 0, 0, 0, 0, '0, 0));
      text_rows.push_back(text_row(CH_LEAD_C2, 0, 0, 0, 0, 0, '0, 0));
      text_rows.push_back(text_row(TR_INV_QUEST, 0, 0, 0, 0, 0, '0, 0));
      // ASCII, zero and unknown trails after a lead still close the pair
      text_rows.push_back(text_row(CH_LEAD_C3, 0, 0, 0, 0, 0, '0, 0));
      text_rows.push_back(text_row(8'h41, 0, 0, 0, 0, 0, '0, 0));
      text_rows.push_back(text_row(8'hE2, 0, 0, 0, 0, 0, '0, 0));
      text_rows.push_back(text_row(CH_HIGH, 0, 0, 0, 0, 0, '0, 0));
      text_rows.push_back(text_row(CH_LEAD_C3, 0, 0, 0, 0, 0, '0, 0));
      text_rows.push_back(text_row(CH_NUL, 0, 0, 0, 0, 0, '0, 0));
      text_rows.push_back(text_row(CH_NUL, 0, 0, 0, 0, 0, '0, 0));
      // string start drops a pending lead
      text_rows.push_back(text_row(CH_LEAD_C3, 0, 0, 0, 0, 0, '0, 0));
      text_rows.push_back(text_row(8'h42, 1, 0, 1, 0, 0, 40'h7F49494936, 0));
      // high byte on the last byte of a string
      text_rows.push_back(text_row(8'hFF, 0, 1, 1, 6, 0, 40'h0201510906, 1));
      text_rows.push_back(text_row(CH_LEAD_C3, 0, 1, 1, 12, 0, 40'h0201510906, 1));
      text_rows.push_back(text_row(CH_LEAD_C3, 0, 0, 0, 0, 0, '0, 0));
      text_rows.push_back(text_row(8'h78, 0, 1, 0, 0, 0, '0, 0));

      foreach (text_rows[i])
         send_byte(text_rows[i].b, text_rows[i].s, text_rows[i].e, text_rows[i].typed,
                   text_rows[i].beat);
      drain_glyphs();

      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: write_regs(100, 50, 4'd0);
            1: write_regs(COORD_MAX, COORD_MAX, 4'd15);
            2: write_regs(COORD_MIN, COORD_MIN, 4'd15);
            3: write_regs(32700, -32700, 4'd8);
            4: write_regs(int'($signed(16'($urandom))), int'($signed(16'($urandom))),
                          4'($urandom));
            5: write_regs(-7, 3, 4'd2);
            default: write_regs($urandom_range(0, 2000) - 1000,
                                $urandom_range(0, 2000) - 1000, 4'd1);
         endcase
         // restart the cursor at the new origin most of the time
         send_byte(8'h41, $urandom_range(0, 3) != 0, 1'b0, 1'b0, '0);
         send_random_text(PHASE_BYTES);
         drain_glyphs();
      end

      $display("run covered %0d bytes over %0d register settings: %0d glyphs, %0d pairs,",
               byte_count, setting_count + 1, glyph_count, pair_count);
      $display("  %0d newlines and %0d saturated cursor updates", line_count, sat_count);
      if (err_count == 0) begin
         $display("tb_utf8_text_glyph_generator: done, clean");
      end else begin
         $display("tb_utf8_text_glyph_generator: done, errors");
      end
      $finish;
   end

endmodule
